### design/multi_button_debounce_press_events_defines.svh
// Assertion macros shared by the press-event debouncer checker.
// No dependencies; include by bare file name.
`ifndef MULTI_BUTTON_DEBOUNCE_PRESS_EVENTS_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_PRESS_EVENTS_DEFINES_SVH

// Clocked assertion, masked while reset is low
`define MBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset
`define MBD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/mbd_pkg.sv
// Package for the press-event debouncer: sizes, register indexes, level codes
// and small bit-vector helpers. No dependencies.
`default_nettype none

package mbd_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int LEVEL_W     = 6;
  localparam int TIME_W      = 32;
  localparam int SEQ_W       = 32;
  localparam int DEB_W       = 16;
  localparam int BTN_IDX_W   = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CNT_W       = $clog2(NUM_BUTTONS + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd1;

  // Register reset values
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd50;
  localparam logic [LEVEL_W-1:0] INVERT_RST   = 6'd32;

  // Pin level codes
  localparam logic LVL_HIGH = 1'b1;
  localparam logic LVL_LOW  = 1'b0;

  typedef logic [NUM_BUTTONS-1:0] btn_vec_t;

  // Load request from the update stage to the result serializer
  typedef struct packed {
    logic             valid;
    btn_vec_t         mask;
    logic [SEQ_W-1:0] first_seq;
  } emit_load_t;

  // Apply the invert mask; buttons past the pin width read low
  function automatic btn_vec_t make_readings(input logic [LEVEL_W-1:0] levels,
                                             input logic [LEVEL_W-1:0] inv);
    logic [NUM_BUTTONS+LEVEL_W-1:0] ext;
    ext = {{NUM_BUTTONS{1'b0}}, levels ^ inv};
    return ext[NUM_BUTTONS-1:0];
  endfunction

  // Number of set bits
  function automatic logic [CNT_W-1:0] popcount(input btn_vec_t v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  // Index of the lowest set bit (zero when none)
  function automatic logic [BTN_IDX_W-1:0] lowest_index(input btn_vec_t v);
    logic [BTN_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BTN_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### design/mbd_emit.sv
// Result serializer: holds one poll's press mask and emits one press per
// transfer in ascending button order. Depends on mbd_pkg.
`default_nettype none

module mbd_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mbd_pkg::emit_load_t            load,
  output logic                           load_ok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mbd_pkg::BTN_IDX_W-1:0]  out_button_index,
  output logic [mbd_pkg::SEQ_W-1:0]      out_sequence_res,
  output logic                           out_last_of_run
);
  import mbd_pkg::*;

  btn_vec_t         pend_r, pend_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic             multi;
  logic             pop;

  // More than one press still queued
  assign multi     = |(pend_r & (pend_r - btn_vec_t'(1)));
  assign out_valid = |pend_r;
  assign pop       = out_valid & out_ready;
  assign load_ok   = ~out_valid | (out_ready & ~multi);

  assign out_button_index = lowest_index(pend_r);
  assign out_sequence_res = seq_r;
  assign out_last_of_run  = ~multi;

  // Drop the lowest press on transfer; a new load replaces the drained mask
  always_comb begin
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    if (pop) begin
      pend_nxt = pend_r & (pend_r - btn_vec_t'(1));
      seq_nxt  = seq_r + SEQ_W'(1);
    end
    if (load.valid) begin
      pend_nxt = load.mask;
      seq_nxt  = load.first_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Sequence payload, meaningful only while presses are queued
  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

endmodule

`default_nettype wire

### design/multi_button_debounce_press_events.sv
// A poll is registered on transfer; once the serializer can take a load, the update stage
// updates the debounce state and loads the presses into the serializer, which offers them.
// Throughput: one poll per cycle while no results are queued; a poll with k presses
// keeps the result serializer busy for k transfers (one press per transfer), up to six.
// Reset (synchronous, rst_n low): levels released, change times and sequence zero,
// debounce 50 ms, invert mask 6'b100000, no results pending.
`default_nettype none

module multi_button_debounce_press_events (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // poll input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mbd_pkg::LEVEL_W-1:0]     in_raw_levels,
  input  logic [mbd_pkg::TIME_W-1:0]      in_now_ms,
  // press results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mbd_pkg::BTN_IDX_W-1:0]   out_button_index,
  output logic [mbd_pkg::SEQ_W-1:0]       out_sequence_res,
  output logic                            out_last_of_run
);
  import mbd_pkg::*;

  // Configuration
  logic [DEB_W-1:0]   debounce_r;
  logic [LEVEL_W-1:0] invert_r;

  // Input register
  logic               s0_valid_r;
  logic [LEVEL_W-1:0] s0_levels_r;
  logic [TIME_W-1:0]  s0_now_r;

  // Debounce state
  btn_vec_t           prev_r, prev_nxt;
  btn_vec_t           stable_r, stable_nxt;
  logic [TIME_W-1:0]  ct_r   [NUM_BUTTONS];
  logic [TIME_W-1:0]  ct_nxt [NUM_BUTTONS];
  logic [SEQ_W-1:0]   seq_r, seq_nxt;

  logic [TIME_W-1:0]  elapsed [NUM_BUTTONS];
  btn_vec_t           readings;
  btn_vec_t           settle;
  btn_vec_t           press;
  logic               load_ok;
  logic               s1_take;
  emit_load_t         load;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      invert_r   <= INVERT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_wdata[DEB_W-1:0];
        REG_INVERT:   invert_r   <= cfg_wdata[LEVEL_W-1:0];
        default:      ;
      endcase
    end
  end

  // Poll register; it frees up as soon as the update stage takes it
  assign s1_take  = s0_valid_r & load_ok;
  assign in_ready = ~s0_valid_r | load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_levels_r <= in_raw_levels;
      s0_now_r    <= in_now_ms;
    end
  end

  // Per-button debounce: each button works on its own bits
  assign readings = make_readings(s0_levels_r, invert_r);

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      ct_nxt[i]     = (readings[i] != prev_r[i]) ? s0_now_r : ct_r[i];
      elapsed[i]    = s0_now_r - ct_nxt[i];
      settle[i]     = (elapsed[i] > TIME_W'(debounce_r)) && (readings[i] != stable_r[i]);
      stable_nxt[i] = settle[i] ? readings[i] : stable_r[i];
      press[i]      = settle[i] && (readings[i] == LVL_LOW);
    end
    prev_nxt = readings;
    seq_nxt  = seq_r + SEQ_W'(popcount(press));
  end

  // Hand the press mask to the serializer with its first sequence number
  always_comb begin
    load.valid     = s1_take;
    load.mask      = press;
    load.first_seq = seq_r + SEQ_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '1;
      stable_r <= '1;
      seq_r    <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        ct_r[i] <= '0;
      end
    end else if (s1_take) begin
      prev_r   <= prev_nxt;
      stable_r <= stable_nxt;
      seq_r    <= seq_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        ct_r[i] <= ct_nxt[i];
      end
    end
  end

  mbd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_sequence_res (out_sequence_res),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire

### design/mbd_checker.sv
// Port-level checker for the press-event debouncer, bound to the top level.
// Depends on mbd_pkg and the assertion macro header.
`default_nettype none
`include "multi_button_debounce_press_events_defines.svh"

module mbd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mbd_pkg::BTN_IDX_W-1:0]  out_button_index,
  input wire logic [mbd_pkg::SEQ_W-1:0]      out_sequence_res,
  input wire logic                           out_last_of_run
);
  import mbd_pkg::*;

  // Stalled result holds
  `MBD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_sequence_res) && $stable(out_button_index)), "result changed while stalled")

  // A run continues right after a non-final transfer, with the next sequence number
  `MBD_ASSERT(a_run_seq, (out_valid && out_ready && !out_last_of_run) |=> (out_valid && (out_sequence_res == $past(out_sequence_res) + SEQ_W'(1))), "press sequence not consecutive within a run")

  // Presses of one poll come in ascending button order
  `MBD_ASSERT(a_run_order, (out_valid && out_ready && !out_last_of_run) |=> (out_button_index > $past(out_button_index)), "button order not ascending within a run")

  // Nothing is offered right after reset
  `MBD_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind multi_button_debounce_press_events mbd_checker u_mbd_checker (.*);

`default_nettype wire

### verif/multi_button_debounce_press_events_tb.sv
// Self-checking testbench for the six-button press-event debouncer.
// Predicts press results from the polls it offers; needs mbd_pkg and the block's RTL.
module multi_button_debounce_press_events_tb;
  import mbd_pkg::*;

  localparam int LONG_HOLD   = 300;   // one long result-side stall
  localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int SETTLE      = 6;     // margin for the poll register and the serializer to empty

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] button;
    logic [SEQ_W-1:0]     seq;
    logic                 last;
  } press_t;

  // Debounce predictor plus the queue of press results still owed by the block
  class press_scoreboard;
    logic [DEB_W-1:0]  debounce;
    btn_vec_t          invert;
    btn_vec_t          prev_reading;
    btn_vec_t          stable;
    logic [TIME_W-1:0] change_time [NUM_BUTTONS];
    logic [SEQ_W-1:0]  press_count;
    press_t            presses_due [$];
    int                errors;

    function new();
      debounce     = DEBOUNCE_RST;
      invert       = INVERT_RST;
      prev_reading = '1;
      stable       = '1;
      foreach (change_time[i]) change_time[i] = '0;
      press_count  = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE: debounce = data;
        REG_INVERT:   invert = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted poll: update debounce state, queue the presses it causes
    function void note_poll(logic [LEVEL_W-1:0] levels, logic [TIME_W-1:0] now);
      btn_vec_t          readings;
      btn_vec_t          pressed;
      logic [TIME_W-1:0] elapsed;
      logic [SEQ_W-1:0]  seqs [NUM_BUTTONS];
      int                last_btn;
      press_t            ev;
      readings = levels ^ invert;
      pressed  = '0;
      last_btn = -1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (readings[i] != prev_reading[i]) change_time[i] = now;
        elapsed = now - change_time[i];
        if (elapsed > TIME_W'(debounce) && readings[i] != stable[i]) begin
          stable[i] = readings[i];
          // stable fall is a press; a stable rise is a silent release
          if (readings[i] == LVL_LOW) begin
            press_count = press_count + 1'b1;
            pressed[i]  = 1'b1;
            seqs[i]     = press_count;
            last_btn    = i;
          end
        end
        prev_reading[i] = readings[i];
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (pressed[i]) begin
          ev.button = BTN_IDX_W'(i);
          ev.seq    = seqs[i];
          ev.last   = (i == last_btn);
          presses_due.push_back(ev);
        end
      end
    endfunction

    // One accepted press result against the oldest one owed
    function void check_press(logic [BTN_IDX_W-1:0] button, logic [SEQ_W-1:0] seq,
                              logic last);
      press_t want;
      if (presses_due.size() == 0) begin
        errors++;
        $display("%0t: press result with none expected: button %0d seq %0d last %0b",
                 $time, button, seq, last);
        return;
      end
      want = presses_due.pop_front();
      if (button !== want.button) begin
        errors++;
        $display("%0t: button_index expected %0d, actual %0d", $time, want.button, button);
      end
      if (seq !== want.seq) begin
        errors++;
        $display("%0t: sequence_res expected %0d, actual %0d", $time, want.seq, seq);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [LEVEL_W-1:0]    in_raw_levels;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [BTN_IDX_W-1:0]  out_button_index;
  logic [SEQ_W-1:0]      out_sequence_res;
  logic                  out_last_of_run;

  press_scoreboard   sb;
  int                polls_accepted = 0;
  int                stall_cycles = 0;
  bit                steady;        // no idling on either side
  bit                hold_results;  // asks the receiver for one long stall
  logic [LEVEL_W-1:0] cur_levels;
  logic [TIME_W-1:0]  cur_time;

  multi_button_debounce_press_events i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_levels    (in_raw_levels),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_sequence_res (out_sequence_res),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Transfers on both channels, seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_press(out_button_index, out_sequence_res, out_last_of_run);
      if (in_valid && in_ready) begin
        sb.note_poll(in_raw_levels, in_now_ms);
        polls_accepted++;
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 1'b0;
        out_ready = 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one poll and return at the falling edge after its transfer
  task automatic send_poll(logic [LEVEL_W-1:0] levels, logic [TIME_W-1:0] now);
    int target;
    in_valid      = 1'b1;
    in_raw_levels = levels;
    in_now_ms     = now;
    target        = polls_accepted + 1;
    do @(negedge clk); while (polls_accepted < target);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering until every owed press has come out and the pipe is empty
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.presses_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly plausible button activity on an advancing clock, some noise
  task automatic send_random_polls(int count, int step_max);
    logic [LEVEL_W-1:0] flips;
    int                 pick;
    for (int k = 0; k < count; k++) begin
      if (!steady && !hold_results && $urandom_range(0, 5) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      flips = '0;
      for (int b = 0; b < LEVEL_W; b++) begin
        if ($urandom_range(0, 3) == 0) flips[b] = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        // arbitrary jump of the clock, often backwards
        cur_time   = $urandom;
        cur_levels = LEVEL_W'($urandom);
      end else if (pick == 8) begin
        cur_time   = cur_time + $urandom_range(0, step_max);
        cur_levels = LEVEL_W'($urandom);
      end else begin
        cur_time   = cur_time + $urandom_range(0, step_max);
        cur_levels = cur_levels ^ flips;
      end
      send_poll(cur_levels, cur_time);
    end
  endtask

  task automatic run_phase(logic [DEB_W-1:0] deb, logic [LEVEL_W-1:0] inv, int count,
                           int step_max);
    drain_results();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_INVERT, {10'($urandom), inv});
    send_random_polls(count, step_max);
  endtask

  initial begin
    int deb;
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_DEBOUNCE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_raw_levels = '1;
    in_now_ms     = '0;
    out_ready     = 1'b0;
    steady        = 1'b0;
    hold_results  = 1'b0;
    cur_levels    = '1;
    cur_time      = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: button 5 inverted, 50 ms hold
    send_poll(6'h3F, 32'd0);      // inverted button reads low, just changed
    send_poll(6'h3F, 32'd100);    // held long enough: press on button 5
    send_poll(6'h00, 32'd100);    // every button changes in the same poll
    send_poll(6'h00, 32'd150);    // elapsed equals the hold: not yet stable
    send_poll(6'h00, 32'd151);    // five presses, button 5 released silently
    send_poll(6'h3F, 32'd200);
    send_poll(6'h3F, 32'd300);    // releases plus one press

    // No hold time, no inversion
    drain_results();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_INVERT, 16'd0);
    send_poll(6'h3F, 32'd1000);
    send_poll(6'h3F, 32'd1001);
    send_poll(6'h00, 32'hFFFF_FFF0);
    send_poll(6'h00, 32'hFFFF_FFFF);  // all six press at once
    send_poll(6'h3F, 32'd5);          // clock wrapped
    send_poll(6'h3F, 32'd16);
    send_poll(6'h00, 32'd256);
    send_poll(6'h00, 32'd80);         // clock went backwards: huge elapsed time
    send_poll(6'h2A, 32'd81);
    send_poll(6'h2A, 32'd82);
    send_poll(6'h15, 32'd82);
    send_poll(6'h15, 32'd83);

    // Short hold with the result side blocked for a long stretch
    drain_results();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_INVERT, 16'd0);
    cur_levels   = '1;
    hold_results = 1'b1;
    send_random_polls(60, 8);

    // Longest hold, everything inverted
    run_phase(16'hFFFF, 6'h3F, 50, 140000);

    // Writes to undecoded indexes must change nothing
    drain_results();
    write_reg(REG_SPARE_2, 16'($urandom));
    write_reg(REG_SPARE_3, 16'($urandom));
    run_phase(16'd20, 6'($urandom), 70, 45);

    // Random short hold; sender waits for every result midway
    deb = $urandom_range(1, 60);
    run_phase(16'(deb), 6'($urandom), 35, 2 * deb + 4);
    drain_results();
    send_random_polls(35, 2 * deb + 4);

    run_phase(16'd1, 6'h2A, 60, 4);

    deb = $urandom_range(0, 65535);
    run_phase(16'(deb), 6'($urandom), 50, 2 * deb + 4);

    // Final stretch at full rate on both sides
    drain_results();
    steady = 1'b1;
    run_phase(16'd10, 6'h15, 80, 25);

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.presses_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
